### rtl/core/ugcd_pkg.sv
// Package with the shared constants, codes and state type of the graph cycle detector.
package ugcd_pkg;

    localparam int VERT_W     = 6;
    localparam int VCOUNT_W   = 7;
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_LSB = 2;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd6;

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_VCOUNT = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_CHK,
        S_EDGE_WB,
        S_EV_INIT,
        S_EV_SCAN,
        S_EV_DEG,
        S_EV_STEP,
        S_EV_NBR,
        S_EV_POP,
        S_EV_DONE
    } t_state;

endpackage

### rtl/core/ugcd_in_if.sv
// Input channel of the graph cycle detector: edge and end-of-case items.
interface ugcd_in_if import ugcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;

    modport source (output valid, output mode, output vertex_a, output vertex_b, input ready);
    modport sink   (input valid, input mode, input vertex_a, input vertex_b, output ready);
endinterface

### rtl/core/ugcd_out_if.sv
// Output channel of the graph cycle detector: one report per evaluated case.
interface ugcd_out_if import ugcd_pkg::*; ();
    logic valid;
    logic ready;
    logic has_cycle;
    logic degree_overflow;

    modport source (output valid, output has_cycle, output degree_overflow, input ready);
    modport sink   (input valid, input has_cycle, input degree_overflow, output ready);
endinterface

### rtl/core/ugcd_deg_table.sv
// Per-vertex degree memory with registered reads, valid bits and a clear of all valid bits at once.
module ugcd_deg_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_clr,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;
    logic             r_rd_vld_a;
    logic             r_rd_vld_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a     <= r_mem[i_raddr_a];
        r_rd_b     <= r_mem[i_raddr_b];
        r_rd_vld_a <= r_vld[i_raddr_a];
        r_rd_vld_b <= r_vld[i_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata_a = r_rd_vld_a ? r_rd_a : '0;
    assign o_rdata_b = r_rd_vld_b ? r_rd_b : '0;

endmodule

### rtl/core/undirected_graph_cycle_detect_unit.sv
// Top level of the undirected graph cycle detector with its walk sequencer.
//
//   Channel   Dir  Handshake        Payload
//   i_in      in   valid / ready    mode, vertex_a, vertex_b
//   o_out     out  valid / ready    has_cycle, degree_overflow
//   APB       in   psel / penable   paddr, pwdata (vertex_count), prdata
//
// An edge item goes through a degree read, a first list append and a second list append.
// A dropped edge ends after the degree check, with no list append.
// An end-of-case item scans the start slots and walks the vertices reached and the stored
// edges, all through one neighbour memory port and one stack port; the walk ends early
// when a cycle is found.
// Reset is synchronous and clears degrees, visited flags and the overflow flag at once.
// Input is not ready while an item is at work; a waiting report stalls only the next report.
module undirected_graph_cycle_detect_unit import ugcd_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DEGREE   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ugcd_in_if.sink               i_in,
    ugcd_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int DIDX_W = $clog2(MAX_DEGREE);
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int U_W    = $clog2(MAX_VERTICES + 1);
    localparam int FRM_W  = 2 * VIDX_W + 1 + 2 * DEG_W;

    t_state                  r_state, n_state;
    logic [VERT_W-1:0]       r_a, n_a;
    logic [VERT_W-1:0]       r_b, n_b;
    logic                    r_ovf, n_ovf;
    logic [VCOUNT_W-1:0]     r_vcount;
    logic [U_W-1:0]          r_u, n_u;
    logic [VIDX_W-1:0]       r_sp, n_sp;
    logic [VIDX_W-1:0]       r_cur, n_cur;
    logic [VIDX_W-1:0]       r_par, n_par;
    logic                    r_has_par, n_has_par;
    logic [DEG_W-1:0]        r_next, n_next;
    logic [DEG_W-1:0]        r_cur_deg, n_cur_deg;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic                    r_cycle, n_cycle;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_cycle, n_out_cycle;
    logic                    r_out_ovf, n_out_ovf;

    logic [VERT_W-1:0] r_nbr_mem [MAX_VERTICES][MAX_DEGREE];
    logic [VERT_W-1:0] r_nbr_rd;
    logic              w_nbr_we;
    logic [VIDX_W-1:0] w_nbr_wv;
    logic [DIDX_W-1:0] w_nbr_wd;
    logic [VERT_W-1:0] w_nbr_wdata;
    logic [VIDX_W-1:0] w_nbr_rv;
    logic [DIDX_W-1:0] w_nbr_rd_idx;

    logic [FRM_W-1:0]  r_stk_mem [MAX_VERTICES];
    logic [FRM_W-1:0]  r_stk_rd;
    logic              w_stk_we;
    logic [VIDX_W-1:0] w_stk_raddr;

    logic              w_deg_we;
    logic [VIDX_W-1:0] w_deg_waddr;
    logic [DEG_W-1:0]  w_deg_wdata;
    logic              w_deg_clr;
    logic [VIDX_W-1:0] w_deg_raddr_a;
    logic [VIDX_W-1:0] w_deg_raddr_b;
    logic [DEG_W-1:0]  w_deg_rd_a;
    logic [DEG_W-1:0]  w_deg_rd_b;

    logic              w_in_ready;
    logic              w_a_ok;
    logic              w_b_ok;
    logic              w_self;
    logic              w_fit;
    logic              w_n_ok;
    logic [VIDX_W-1:0] w_n_idx;
    logic [VIDX_W-1:0] w_u_idx;
    logic              w_u_live;
    logic              w_cfg_we;

    ugcd_deg_table #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (DEG_W)
    ) u_deg_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_deg_we),
        .i_waddr   (w_deg_waddr),
        .i_wdata   (w_deg_wdata),
        .i_clr     (w_deg_clr),
        .i_raddr_a (w_deg_raddr_a),
        .i_raddr_b (w_deg_raddr_b),
        .o_rdata_a (w_deg_rd_a),
        .o_rdata_b (w_deg_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (w_nbr_we) begin
            r_nbr_mem[w_nbr_wv][w_nbr_wd] <= w_nbr_wdata;
        end
        r_nbr_rd <= r_nbr_mem[w_nbr_rv][w_nbr_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[r_sp] <= {r_cur, r_par, r_has_par, r_next, r_cur_deg};
        end
        r_stk_rd <= r_stk_mem[w_stk_raddr];
    end

    assign w_cfg_we = psel && penable && pwrite
                      && (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_VCOUNT);
    assign pready   = 1'b1;
    assign prdata   = (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_VCOUNT)
                      ? APB_DATA_W'(r_vcount) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (w_cfg_we) begin
            r_vcount <= pwdata[VCOUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovf       <= 1'b0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
            r_sp        <= '0;
            r_cycle     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ovf       <= n_ovf;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
            r_sp        <= n_sp;
            r_cycle     <= n_cycle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_u         <= n_u;
        r_cur       <= n_cur;
        r_par       <= n_par;
        r_has_par   <= n_has_par;
        r_next      <= n_next;
        r_cur_deg   <= n_cur_deg;
        r_out_cycle <= n_out_cycle;
        r_out_ovf   <= n_out_ovf;
    end

    assign w_a_ok   = 32'(r_a) < MAX_VERTICES;
    assign w_b_ok   = 32'(r_b) < MAX_VERTICES;
    assign w_self   = (r_a == r_b);
    assign w_fit    = w_self ? (32'(w_deg_rd_a) + 32'd2 <= MAX_DEGREE)
                             : ((32'(w_deg_rd_a) + 32'd1 <= MAX_DEGREE)
                                && (32'(w_deg_rd_b) + 32'd1 <= MAX_DEGREE));
    assign w_n_ok   = 32'(r_nbr_rd) < MAX_VERTICES;
    assign w_n_idx  = VIDX_W'(r_nbr_rd);
    assign w_u_idx  = VIDX_W'(r_u);
    assign w_u_live = (32'(r_u) < 32'(r_vcount)) && (32'(r_u) < MAX_VERTICES);

    always_comb begin
        n_state       = r_state;
        n_a           = r_a;
        n_b           = r_b;
        n_ovf         = r_ovf;
        n_u           = r_u;
        n_sp          = r_sp;
        n_cur         = r_cur;
        n_par         = r_par;
        n_has_par     = r_has_par;
        n_next        = r_next;
        n_cur_deg     = r_cur_deg;
        n_visited     = r_visited;
        n_cycle       = r_cycle;
        n_out_valid   = r_out_valid;
        n_out_cycle   = r_out_cycle;
        n_out_ovf     = r_out_ovf;
        w_in_ready    = 1'b0;
        w_nbr_we      = 1'b0;
        w_nbr_wv      = VIDX_W'(r_a);
        w_nbr_wd      = DIDX_W'(w_deg_rd_a);
        w_nbr_wdata   = r_b;
        w_nbr_rv      = r_cur;
        w_nbr_rd_idx  = DIDX_W'(r_next);
        w_stk_we      = 1'b0;
        w_stk_raddr   = r_sp - 1'b1;
        w_deg_we      = 1'b0;
        w_deg_waddr   = VIDX_W'(r_a);
        w_deg_wdata   = DEG_W'(w_deg_rd_a + 1'b1);
        w_deg_clr     = 1'b0;
        w_deg_raddr_a = VIDX_W'(i_in.vertex_a);
        w_deg_raddr_b = VIDX_W'(i_in.vertex_b);

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_a = i_in.vertex_a;
                    n_b = i_in.vertex_b;
                    if (i_in.mode == MODE_EVAL) begin
                        n_state = S_EV_INIT;
                    end else begin
                        n_state = S_EDGE_CHK;
                    end
                end
            end
            S_EDGE_CHK: begin
                n_state = S_IDLE;
                if (w_a_ok && w_b_ok) begin
                    if (!w_fit) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_nbr_we  = 1'b1;
                        w_deg_we  = 1'b1;
                        n_cur_deg = w_self ? DEG_W'(w_deg_rd_a + 1'b1) : w_deg_rd_b;
                        n_state   = S_EDGE_WB;
                    end
                end
            end
            S_EDGE_WB: begin
                w_nbr_we    = 1'b1;
                w_nbr_wv    = VIDX_W'(r_b);
                w_nbr_wd    = DIDX_W'(r_cur_deg);
                w_nbr_wdata = r_a;
                w_deg_we    = 1'b1;
                w_deg_waddr = VIDX_W'(r_b);
                w_deg_wdata = DEG_W'(r_cur_deg + 1'b1);
                n_state     = S_IDLE;
            end
            S_EV_INIT: begin
                n_visited = '0;
                n_u       = '0;
                n_cycle   = 1'b0;
                n_state   = S_EV_SCAN;
            end
            S_EV_SCAN: begin
                w_deg_raddr_a = w_u_idx;
                if (!w_u_live) begin
                    n_state = S_EV_DONE;
                end else if (r_visited[w_u_idx]) begin
                    n_u = U_W'(r_u + 1'b1);
                end else begin
                    n_visited[w_u_idx] = 1'b1;
                    n_cur     = w_u_idx;
                    n_par     = '0;
                    n_has_par = 1'b0;
                    n_next    = '0;
                    n_sp      = '0;
                    n_state   = S_EV_DEG;
                end
            end
            S_EV_DEG: begin
                n_cur_deg = w_deg_rd_a;
                n_state   = S_EV_STEP;
            end
            S_EV_STEP: begin
                if (r_next < r_cur_deg) begin
                    n_next  = DEG_W'(r_next + 1'b1);
                    n_state = S_EV_NBR;
                end else if (r_sp == '0) begin
                    n_state = S_EV_SCAN;
                end else begin
                    n_sp    = r_sp - 1'b1;
                    n_state = S_EV_POP;
                end
            end
            S_EV_NBR: begin
                w_deg_raddr_a = w_n_idx;
                if (!w_n_ok) begin
                    n_state = S_EV_STEP;
                end else if (!r_visited[w_n_idx]) begin
                    w_stk_we  = 1'b1;
                    n_sp      = r_sp + 1'b1;
                    n_visited[w_n_idx] = 1'b1;
                    n_par     = r_cur;
                    n_cur     = w_n_idx;
                    n_has_par = 1'b1;
                    n_next    = '0;
                    n_state   = S_EV_DEG;
                end else if (!r_has_par || (w_n_idx != r_par)) begin
                    n_cycle = 1'b1;
                    n_state = S_EV_DONE;
                end else begin
                    n_state = S_EV_STEP;
                end
            end
            S_EV_POP: begin
                {n_cur, n_par, n_has_par, n_next, n_cur_deg} = r_stk_rd;
                n_state = S_EV_STEP;
            end
            S_EV_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cycle = r_cycle;
                    n_out_ovf   = r_ovf;
                    n_ovf       = 1'b0;
                    n_visited   = '0;
                    w_deg_clr   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready            = w_in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.has_cycle       = r_out_cycle;
    assign o_out.degree_overflow = r_out_ovf;

`ifndef ASSERT_OFF
    a_edge_goes_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.mode == MODE_EDGE)) |=> (r_state == S_EDGE_CHK))
        else $error("Accepted edge transfer did not start the degree check.");

    a_report_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_EV_DONE))
        else $error("Report raised outside the done state.");

    a_clear_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EV_DONE) && (n_state == S_IDLE)) |=> ((r_visited == '0) && !r_ovf))
        else $error("Visited flags or overflow flag survived the report.");

    a_root_has_no_parent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EV_STEP) && (r_sp == '0)) |-> !r_has_par)
        else $error("Bottom frame of a walk carries a parent.");

    a_walk_vertex_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV_STEP) |-> r_visited[r_cur])
        else $error("Current walk vertex is not marked visited.");
`endif

endmodule

### test/ugcd_cycle_check.sv
`timescale 1ns / 100ps
// Checker that predicts the cycle reports of the graph cycle detector and compares them.
module ugcd_cycle_check import ugcd_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DEGREE   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ugcd_in_if                    i_item_ch,
    ugcd_out_if                   i_report_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic has_cycle;
        logic degree_overflow;
    } t_cycle_report;

    t_cycle_report       expected_reports [$];
    logic [VERT_W-1:0]   adjacency [MAX_VERTICES][MAX_DEGREE];
    int unsigned         vertex_degree [MAX_VERTICES];
    logic                overflow_seen;
    logic [VCOUNT_W-1:0] start_count;
    int                  fail_total = 0;

    function automatic void insert_edge(int unsigned a, int unsigned b);
        if (a >= MAX_VERTICES || b >= MAX_VERTICES) begin
            return;
        end
        if (a == b) begin
            if (vertex_degree[a] + 2 > MAX_DEGREE) begin
                overflow_seen = 1'b1;
                return;
            end
        end else if (vertex_degree[a] + 1 > MAX_DEGREE || vertex_degree[b] + 1 > MAX_DEGREE) begin
            overflow_seen = 1'b1;
            return;
        end
        adjacency[a][vertex_degree[a]] = VERT_W'(b);
        vertex_degree[a]++;
        adjacency[b][vertex_degree[b]] = VERT_W'(a);
        vertex_degree[b]++;
    endfunction

    function automatic logic find_cycle();
        logic        marked [MAX_VERTICES];
        int unsigned frame_vert [MAX_VERTICES+1];
        int unsigned frame_parent [MAX_VERTICES+1];
        logic        frame_rooted [MAX_VERTICES+1];
        int unsigned frame_next [MAX_VERTICES+1];
        int unsigned depth;
        int unsigned limit;
        int unsigned cur;
        int unsigned nbr;
        limit = (32'(start_count) > MAX_VERTICES) ? MAX_VERTICES : 32'(start_count);
        for (int v = 0; v < MAX_VERTICES; v++) begin
            marked[v] = 1'b0;
        end
        for (int unsigned root = 0; root < limit; root++) begin
            if (!marked[root]) begin
                marked[root]    = 1'b1;
                frame_vert[0]   = root;
                frame_parent[0] = 0;
                frame_rooted[0] = 1'b1;
                frame_next[0]   = 0;
                depth           = 1;
                while (depth > 0) begin
                    cur = frame_vert[depth-1];
                    if (frame_next[depth-1] < vertex_degree[cur] &&
                        frame_next[depth-1] < MAX_DEGREE) begin
                        nbr = 32'(adjacency[cur][frame_next[depth-1]]);
                        frame_next[depth-1]++;
                        if (nbr < MAX_VERTICES) begin
                            if (!marked[nbr]) begin
                                if (depth > MAX_VERTICES) begin
                                    return 1'b1;
                                end
                                marked[nbr]         = 1'b1;
                                frame_vert[depth]   = nbr;
                                frame_parent[depth] = cur;
                                frame_rooted[depth] = 1'b0;
                                frame_next[depth]   = 0;
                                depth++;
                            end else if (frame_rooted[depth-1] ||
                                         nbr != frame_parent[depth-1]) begin
                                return 1'b1;
                            end
                        end
                    end else begin
                        depth--;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_cycle_report want;
        if (!i_rst_n) begin
            for (int v = 0; v < MAX_VERTICES; v++) begin
                vertex_degree[v] = 0;
            end
            overflow_seen = 1'b0;
            start_count   = VCOUNT_RESET;
            expected_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_VCOUNT) begin
                start_count = pwdata[VCOUNT_W-1:0];
            end
            if (i_report_ch.valid && i_report_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("report transfer with no report expected");
                    fail_total++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_report_ch.has_cycle !== want.has_cycle) begin
                        $error("has_cycle: expected %0b, actual %0b",
                               want.has_cycle, i_report_ch.has_cycle);
                        fail_total++;
                    end
                    if (i_report_ch.degree_overflow !== want.degree_overflow) begin
                        $error("degree_overflow: expected %0b, actual %0b",
                               want.degree_overflow, i_report_ch.degree_overflow);
                        fail_total++;
                    end
                end
            end
            if (i_item_ch.valid && i_item_ch.ready) begin
                if (i_item_ch.mode == MODE_EDGE) begin
                    insert_edge(32'(i_item_ch.vertex_a), 32'(i_item_ch.vertex_b));
                end else begin
                    want.has_cycle       = find_cycle();
                    want.degree_overflow = overflow_seen;
                    expected_reports.push_back(want);
                    for (int v = 0; v < MAX_VERTICES; v++) begin
                        vertex_degree[v] = 0;
                    end
                    overflow_seen = 1'b0;
                end
            end
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= fail_total;
    end

endmodule

### test/undirected_graph_cycle_detect_unit_tb.sv
`timescale 1ns / 100ps
// Top of the graph cycle detector testbench with clock, reset, stimulus and verdict.
module undirected_graph_cycle_detect_unit_tb;
    import ugcd_pkg::*;

    localparam int MAX_VERTICES  = 64;
    localparam int MAX_DEGREE    = 64;
    localparam int ITEM_TOTAL    = 1400;
    localparam int PHASE_COUNT   = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum int {
        CASE_TREE,
        CASE_SPARSE,
        CASE_NOISE,
        CASE_HUB,
        CASE_CHAIN,
        CASE_SCATTER
    } t_case_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending_count;
    int                    items_sent;
    int                    cycle_count;
    int                    send_idle_pct;
    int                    recv_stall_pct;

    ugcd_in_if  in_ch ();
    ugcd_out_if out_ch ();

    undirected_graph_cycle_detect_unit #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ugcd_cycle_check #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_cycle_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_ch    (in_ch),
        .i_report_ch  (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL undirected_graph_cycle_detect_unit");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic item_mode, input logic [VERT_W-1:0] a,
                             input logic [VERT_W-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= item_mode;
        in_ch.vertex_a <= a;
        in_ch.vertex_b <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_edge(input int a, input int b);
        if ($urandom_range(0, 1)) begin
            send_item(MODE_EDGE, VERT_W'(b), VERT_W'(a));
        end else begin
            send_item(MODE_EDGE, VERT_W'(a), VERT_W'(b));
        end
    endtask

    task automatic end_case();
        send_item(MODE_EVAL, VERT_W'($urandom()), VERT_W'($urandom()));
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_count(input logic [VCOUNT_W-1:0] value);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(REG_VCOUNT) << CFG_IDX_LSB;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [VCOUNT_W-1:0] pick_start_count();
        case ($urandom_range(0, 11))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd127;
            3:       return 7'd65;
            4:       return 7'd63;
            5, 6, 7: return 7'd64;
            default: return VCOUNT_W'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic run_case(input t_case_kind kind);
        int nv;
        int base;
        int count;
        int hub;
        int pick;
        int swap;
        int order [MAX_VERTICES];
        case (kind)
            CASE_TREE: begin
                nv   = $urandom_range(2, 10);
                base = $urandom_range(0, MAX_VERTICES - nv);
                for (int i = 1; i < nv; i++) begin
                    send_edge(base + i, base + $urandom_range(0, i - 1));
                end
                if ($urandom_range(0, 1)) begin
                    send_edge(base + $urandom_range(0, nv - 1), base + $urandom_range(0, nv - 1));
                end
            end
            CASE_SPARSE: begin
                nv    = $urandom_range(1, 12);
                base  = $urandom_range(0, MAX_VERTICES - nv);
                count = $urandom_range(0, 10);
                for (int i = 0; i < count; i++) begin
                    send_edge(base + $urandom_range(0, nv - 1), base + $urandom_range(0, nv - 1));
                end
            end
            CASE_NOISE: begin
                count = $urandom_range(1, 8);
                for (int i = 0; i < count; i++) begin
                    send_item(($urandom_range(0, 7) == 0) ? MODE_EVAL : MODE_EDGE,
                              VERT_W'($urandom()), VERT_W'($urandom()));
                end
            end
            CASE_HUB: begin
                hub   = $urandom_range(0, MAX_VERTICES - 1);
                count = $urandom_range(60, 70);
                for (int i = 0; i < count; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_edge(hub, hub);
                    end else begin
                        send_edge(hub, $urandom_range(0, MAX_VERTICES - 1));
                    end
                end
            end
            CASE_CHAIN: begin
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    order[i] = i;
                end
                for (int i = MAX_VERTICES - 1; i > 0; i--) begin
                    pick        = $urandom_range(0, i);
                    swap        = order[i];
                    order[i]    = order[pick];
                    order[pick] = swap;
                end
                nv = $urandom_range(8, MAX_VERTICES);
                for (int i = 1; i < nv; i++) begin
                    send_edge(order[i - 1], order[i]);
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_edge(order[nv - 1], order[0]);
                end
            end
            default: begin
                count = $urandom_range(0, 12);
                for (int i = 0; i < count; i++) begin
                    send_edge($urandom_range(0, MAX_VERTICES - 1),
                              $urandom_range(0, MAX_VERTICES - 1));
                end
            end
        endcase
        end_case();
    endtask

    initial begin
        int         phase_end;
        int         case_index;
        int         roll;
        t_case_kind kind;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_EDGE;
        in_ch.vertex_a = '0;
        in_ch.vertex_b = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        case_index     = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        end_case();
        send_edge(0, 1);
        send_edge(1, 2);
        send_edge(2, 0);
        end_case();
        send_edge(0, 63);
        send_edge(63, 5);
        end_case();
        send_edge(3, 3);
        end_case();
        send_edge(4, 5);
        send_edge(5, 4);
        end_case();
        write_start_count(7'd0);
        send_edge(0, 1);
        send_edge(1, 2);
        send_edge(2, 0);
        end_case();
        write_start_count(7'd127);
        send_edge(62, 63);
        send_edge(63, 61);
        send_edge(61, 62);
        end_case();
        write_start_count(7'd1);
        send_edge(63, 63);
        end_case();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            write_start_count((phase == 0) ? 7'd64 : pick_start_count());
            phase_end = items_sent + ITEM_TOTAL / PHASE_COUNT;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 4) == 0) begin
                    write_start_count(pick_start_count());
                end else if ($urandom_range(0, 19) == 0) begin
                    wait_drain();
                end
                roll = $urandom_range(0, 19);
                if (case_index % 12 == 0 || roll == 13) begin
                    kind = CASE_HUB;
                end else if (roll <= 6) begin
                    kind = CASE_TREE;
                end else if (roll <= 10) begin
                    kind = CASE_SPARSE;
                end else if (roll <= 12) begin
                    kind = CASE_NOISE;
                end else if (roll <= 15) begin
                    kind = CASE_CHAIN;
                end else begin
                    kind = CASE_SCATTER;
                end
                run_case(kind);
                case_index++;
            end
        end

        wait_drain();
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS undirected_graph_cycle_detect_unit");
        end else begin
            $display("FAIL undirected_graph_cycle_detect_unit");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/ugcd_pkg.sv
rtl/core/ugcd_in_if.sv
rtl/core/ugcd_out_if.sv
rtl/core/ugcd_deg_table.sv
rtl/core/undirected_graph_cycle_detect_unit.sv
test/ugcd_cycle_check.sv
test/undirected_graph_cycle_detect_unit_tb.sv
